// ===== src/pmct_pkg.sv =====
// Package: shared types, widths and helper functions for the PS/2 cursor tracker.
`default_nettype none
package pmct_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int OUT_W       = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int DELTA_W     = 11;
    localparam int WIDE_W      = ((COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W) + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DELTA_W-1:0] OVF_EXTRA  = DELTA_W'(255);

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_DX,
        PH_DY
    } phase_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] dx;
        logic [7:0] dy;
    } pkt_t;

    // Signed movement of one axis, with the overflow bit adding 255 more travel.
    function automatic logic signed [DELTA_W-1:0] axis_delta(
        input logic [7:0] mag,
        input logic       neg,
        input logic       ovf
    );
        logic signed [DELTA_W-1:0] d;
        if (neg)
        begin
            d = (mag == 8'd0) ? '0 : $signed({3'b111, mag});
            if (ovf)
            begin
                d = d - $signed(OVF_EXTRA);
            end
        end
        else
        begin
            d = $signed({3'b000, mag});
            if (ovf)
            begin
                d = d + $signed(OVF_EXTRA);
            end
        end
        return d;
    endfunction

    // Clamp to zero below, then to min(dim-1, coordinate max) above.
    function automatic logic [COORD_WIDTH-1:0] clamp_axis(
        input logic signed [WIDE_W-1:0] v,
        input logic [DIM_W-1:0]         dim
    );
        logic signed [WIDE_W-1:0] top;
        logic signed [WIDE_W-1:0] lim;
        logic signed [WIDE_W-1:0] r;
        top = $signed(WIDE_W'((64'd1 << COORD_WIDTH) - 64'd1));
        lim = (dim == '0) ? '0 : $signed(WIDE_W'(dim - DIM_W'(1)));
        if (lim > top)
        begin
            lim = top;
        end
        r = v;
        if (r < 0)
        begin
            r = '0;
        end
        if (r > lim)
        begin
            r = lim;
        end
        return COORD_WIDTH'(r);
    endfunction

endpackage
`default_nettype wire

// ===== src/pmct_front.sv =====
// Front end: assembles received bytes into three-byte packets and hands them on.
`default_nettype none
module pmct_front
    import pmct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            push_valid,
    input  wire logic       push_ready,
    output pkt_t            push_pkt
);

    phase_t     phase_reg, phase_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] dx_reg, dx_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STATUS;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        dx_reg     <= dx_next;
    end

    always_comb
    begin
        // Only the closing byte needs queue space.
        in_ready    = (phase_reg != PH_DY) || push_ready;
        accept      = in_valid && in_ready;
        push_valid  = in_valid && (phase_reg == PH_DY);
        push_pkt    = '{status: status_reg, dx: dx_reg, dy: rx_byte};
        phase_next  = phase_reg;
        status_next = status_reg;
        dx_next     = dx_reg;
        case (phase_reg)
            PH_STATUS:
            begin
                // Drop bytes without the sync bit; they cannot open a packet.
                if (accept && rx_byte[SYNC_BIT])
                begin
                    status_next = rx_byte;
                    phase_next  = PH_DX;
                end
            end
            PH_DX:
            begin
                if (accept)
                begin
                    dx_next    = rx_byte;
                    phase_next = PH_DY;
                end
            end
            PH_DY:
            begin
                if (accept)
                begin
                    phase_next = PH_STATUS;
                end
            end
            default:
            begin
                phase_next = PH_STATUS;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/pmct_queue.sv =====
// Packet queue: short FIFO between the byte assembler and the position update.
`default_nettype none
module pmct_queue
    import pmct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire pkt_t push_pkt,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output pkt_t      pop_pkt
);

    pkt_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid   = (count_reg != '0);
        pop_pkt     = entry_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule
`default_nettype wire

// ===== src/pmct_back.sv =====
// Back end: applies packet motion to the cursor, clamps it and holds the result.
`default_nettype none
module pmct_back
    import pmct_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [DIM_W-1:0] screen_width,
    input  wire logic [DIM_W-1:0] screen_height,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire pkt_t             pop_pkt,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [OUT_W-1:0]      cursor_x,
    output logic [OUT_W-1:0]      cursor_y,
    output logic                  left_button,
    output logic                  right_button,
    output logic                  middle_button
);

    logic [COORD_WIDTH-1:0]    pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0]    pos_y_reg, pos_y_next;
    logic                      valid_reg;
    logic [2:0]                buttons_reg;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [WIDE_W-1:0]  sum_x;
    logic signed [WIDE_W-1:0]  sum_y;
    logic                      take;

    always_comb
    begin
        pop_ready = !valid_reg || out_ready;
        take      = pop_valid && pop_ready;
        dx = axis_delta(pop_pkt.dx, pop_pkt.status[XSIGN_BIT], pop_pkt.status[XOVF_BIT]);
        dy = axis_delta(pop_pkt.dy, pop_pkt.status[YSIGN_BIT], pop_pkt.status[YOVF_BIT]);
        sum_x = $signed(WIDE_W'(pos_x_reg)) + WIDE_W'(dx);
        // Positive Y moves toward row zero.
        sum_y = $signed(WIDE_W'(pos_y_reg)) - WIDE_W'(dy);
        pos_x_next = clamp_axis(sum_x, screen_width);
        pos_y_next = clamp_axis(sum_y, screen_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buttons_reg <= pop_pkt.status[2:0];
        end
    end

    assign out_valid     = valid_reg;
    assign cursor_x      = OUT_W'(pos_x_reg);
    assign cursor_y      = OUT_W'(pos_y_reg);
    assign left_button   = buttons_reg[0];
    assign right_button  = buttons_reg[1];
    assign middle_button = buttons_reg[2];

endmodule
`default_nettype wire

// ===== src/ps2_mouse_cursor_tracker_unit.sv =====
// Top level: PS/2 mouse packet decoder with clamped cursor tracking.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | rx_byte[7:0]
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index[3:0], cfg_data[12:0]
//  out     | output    | out_valid / out_ready | cursor_x, cursor_y, left/right/middle
//
// One byte is taken per cycle while in_ready is high. The closing byte of a packet
// is pushed into a two-entry packet queue; the packet at the queue head passes
// through the single add-and-clamp stage in the back end, whose output is registered.
// Reset (rst_n low, asynchronous) returns the assembler to waiting for a status
// byte, empties the queue, zeroes the cursor and restores 640 x 480.
// in_ready drops only for a closing byte while the queue is full; the other
// bytes are always taken. Configuration requests are always taken.
`default_nettype none
module ps2_mouse_cursor_tracker_unit
    import pmct_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_W-1:0]          cursor_x,
    output logic [OUT_W-1:0]          cursor_y,
    output logic                      left_button,
    output logic                      right_button,
    output logic                      middle_button
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             push_valid;
    logic             push_ready;
    pkt_t             push_pkt;
    logic             pop_valid;
    logic             pop_ready;
    pkt_t             pop_pkt;

    // Configuration registers; a request to an unknown index is taken and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Assemble bytes into packets.
    pmct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt)
    );

    // Hold finished packets so the assembler keeps taking bytes while the output stalls.
    pmct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_pkt    (pop_pkt)
    );

    // Advance the cursor and present the result.
    pmct_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_pkt       (pop_pkt),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .left_button   (left_button),
        .right_button  (right_button),
        .middle_button (middle_button)
    );

endmodule
`default_nettype wire

// ===== src/pmct_checker.sv =====
// Checker: port-level assertions for the cursor tracker, bound to the top level.
`default_nettype none
module pmct_checker
    import pmct_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic [7:0]       rx_byte,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [OUT_W-1:0] cursor_x,
    input wire logic [OUT_W-1:0] cursor_y,
    input wire logic             left_button,
    input wire logic             right_button,
    input wire logic             middle_button
);

    // Track packet phase and outstanding results from the ports alone.
    phase_t     phase_reg;
    logic [2:0] pending_reg;
    logic       in_acc;
    logic       out_acc;
    logic       closes;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign closes  = in_acc && (phase_reg == PH_DY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STATUS;
            pending_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                case (phase_reg)
                    PH_STATUS: phase_reg <= rx_byte[SYNC_BIT] ? PH_DX : PH_STATUS;
                    PH_DX:     phase_reg <= PH_DY;
                    default:   phase_reg <= PH_STATUS;
                endcase
            end
            pending_reg <= pending_reg + 3'(closes) - 3'(out_acc);
        end
    end

    // A result needs a completed packet behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 3'd0))
        else $error("result delivered with no completed packet outstanding");

    // Queue plus output register bound the results in flight.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more packets in flight than the block can hold");

    // Bytes that do not close a packet are never held off.
    a_open_bytes_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DY) |-> in_ready)
        else $error("input stalled on a byte that does not close a packet");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(left_button) && $stable(right_button) && $stable(middle_button)))
        else $error("stalled result changed or vanished");

endmodule

bind ps2_mouse_cursor_tracker_unit pmct_checker u_pmct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .left_button   (left_button),
    .right_button  (right_button),
    .middle_button (middle_button)
);
`default_nettype wire
